FILE: rtl/iaedm_pkg.sv
// Package: opcodes, widths and stage types for the integer ALU divmod core.
package iaedm_pkg;
    localparam int DataWidth = 32;
    localparam int FuncWidth = 4;
    localparam int MagWidth  = DataWidth;
    localparam int StepsPerStage = 4;
    localparam int DivStages = DataWidth / StepsPerStage;

    typedef enum logic [FuncWidth-1:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_DIV  = 4'd3,
        FN_MOD  = 4'd4,
        FN_QUOT = 4'd5,
        FN_REM  = 4'd6,
        FN_NEG  = 4'd7,
        FN_EQ   = 4'd8,
        FN_GT   = 4'd9,
        FN_LT   = 4'd10,
        FN_CMP  = 4'd11
    } t_func;

    localparam logic [DataWidth-1:0] CmpEq = DataWidth'(0);
    localparam logic [DataWidth-1:0] CmpGt = DataWidth'(1);
    localparam logic [DataWidth-1:0] CmpLt = DataWidth'(2);

    // Sideband that travels with every item through the divider stages
    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic                 is_div;
        logic                 div_zero;
        logic                 a_neg;
        logic                 b_neg;
        logic [DataWidth-1:0] early_result;
    } t_side;
endpackage

FILE: rtl/integer_alu_euclidean_divmod_core.sv
// Top level: pipelined signed ALU with Euclidean and truncated divide.
//
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   func[3:0], operand_a[35:4], operand_b[67:36] -
// m_axis   out  result[31:0]                                 div_by_zero
//
// Every item passes through one operand stage, eight divider stages of four
// restoring steps each, one sign fixup stage that also carries the product,
// and the output register. One item enters per cycle unless stalled. The
// pipeline advances whenever the output is empty or taken; a stall freezes
// all stages. Reset clears only the valid bits.
module integer_alu_euclidean_divmod_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // func, operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result
    output logic        m_axis_tuser   // div_by_zero
);
    localparam int W = iaedm_pkg::DataWidth;
    localparam int S = iaedm_pkg::DivStages;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [3:0]   in_func;
    logic [W-1:0] in_a;
    logic [W-1:0] in_b;
    assign in_func = s_axis_tdata[3:0];
    assign in_a    = s_axis_tdata[35:4];
    assign in_b    = s_axis_tdata[67:36];

    // Stage 0: decode, simple ops, magnitudes
    iaedm_pkg::t_side n_side;
    logic [W-1:0]     ma, mb;
    logic             slt_ab, slt_ba;
    always_comb begin
        slt_ab = $signed(in_a) < $signed(in_b);
        slt_ba = $signed(in_b) < $signed(in_a);
        n_side.func     = in_func;
        n_side.is_div   = (in_func == iaedm_pkg::FN_DIV) || (in_func == iaedm_pkg::FN_MOD) ||
                          (in_func == iaedm_pkg::FN_QUOT) || (in_func == iaedm_pkg::FN_REM);
        n_side.div_zero = n_side.is_div && (in_b == '0);
        n_side.a_neg    = in_a[W-1];
        n_side.b_neg    = in_b[W-1];
        case (in_func)
            iaedm_pkg::FN_ADD: n_side.early_result = in_a + in_b;
            iaedm_pkg::FN_SUB: n_side.early_result = in_a - in_b;
            iaedm_pkg::FN_NEG: n_side.early_result = '0 - in_a;
            iaedm_pkg::FN_EQ:  n_side.early_result = W'(in_a == in_b);
            iaedm_pkg::FN_GT:  n_side.early_result = W'(slt_ba);
            iaedm_pkg::FN_LT:  n_side.early_result = W'(slt_ab);
            iaedm_pkg::FN_CMP: n_side.early_result = slt_ab ? iaedm_pkg::CmpLt :
                                   (in_a == in_b ? iaedm_pkg::CmpEq : iaedm_pkg::CmpGt);
            default:           n_side.early_result = '0;
        endcase
        ma = in_a[W-1] ? ('0 - in_a) : in_a;
        mb = in_b[W-1] ? ('0 - in_b) : in_b;
    end

    logic             r_v0;
    iaedm_pkg::t_side r_side0;
    logic [W-1:0]     r_ma0, r_mb0, r_a0, r_b0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side0 <= n_side;
            r_ma0   <= ma;
            r_mb0   <= mb;
            r_a0    <= in_a;
            r_b0    <= in_b;
        end
    end

    // Multiplier: one 32x32 low product registered, then delayed to match the divider
    logic [W-1:0] r_prod [S];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod[0] <= r_a0 * r_b0;
            for (int k = 1; k < S; k++) r_prod[k] <= r_prod[k-1];
        end
    end

    // Divider chain
    logic             v_c   [S+1];
    iaedm_pkg::t_side sd_c  [S+1];
    logic [W-1:0]     rem_c [S+1];
    logic [W-1:0]     quo_c [S+1];
    logic [W-1:0]     div_c [S+1];
    assign v_c[0]   = r_v0;
    assign sd_c[0]  = r_side0;
    assign rem_c[0] = '0;
    assign quo_c[0] = r_ma0;
    assign div_c[0] = r_mb0;

    for (genvar g = 0; g < S; g++) begin : g_div
        iaedm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_c[g]),
            .i_side  (sd_c[g]),
            .i_rem   (rem_c[g]),
            .i_quo   (quo_c[g]),
            .i_div   (div_c[g]),
            .o_valid (v_c[g+1]),
            .o_side  (sd_c[g+1]),
            .o_rem   (rem_c[g+1]),
            .o_quo   (quo_c[g+1]),
            .o_div   (div_c[g+1])
        );
    end

    // Sign fixup stage: truncated results and Euclidean adjust terms
    iaedm_pkg::t_side sd;
    logic [W-1:0]     q, m, mb_f;
    logic [W-1:0]     tq, tr;
    logic             adj;
    assign sd   = sd_c[S];
    assign q    = quo_c[S];
    assign m    = rem_c[S];
    assign mb_f = div_c[S];

    logic             r_vf;
    logic [W-1:0]     r_tq, r_tr, r_mod, r_prodf;
    logic             r_adj;
    iaedm_pkg::t_side r_sdf;
    always_comb begin
        tq  = (sd.a_neg != sd.b_neg) ? ('0 - q) : q;
        tr  = sd.a_neg ? ('0 - m) : m;
        adj = sd.a_neg && (m != '0);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (en) begin
            r_vf <= v_c[S];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tq    <= tq;
            r_tr    <= tr;
            r_mod   <= adj ? (mb_f - m) : m;
            r_adj   <= adj;
            r_sdf   <= sd;
            r_prodf <= r_prod[S-1];
        end
    end

    // Final select into the output register
    logic [W-1:0] n_res;
    always_comb begin
        if (r_sdf.div_zero) begin
            n_res = '0;
        end else begin
            case (r_sdf.func)
                iaedm_pkg::FN_MUL:  n_res = r_prodf;
                iaedm_pkg::FN_QUOT: n_res = r_tq;
                iaedm_pkg::FN_REM:  n_res = r_tr;
                iaedm_pkg::FN_MOD:  n_res = r_mod;
                iaedm_pkg::FN_DIV:  n_res = !r_adj ? r_tq :
                                        (r_sdf.b_neg ? r_tq + W'(1) : r_tq - W'(1));
                default:            n_res = r_sdf.early_result;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_vf;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= n_res;
            m_axis_tuser <= r_sdf.div_zero;
        end
    end
endmodule

FILE: rtl/iaedm_div_stage.sv
// One divider pipeline stage: StepsPerStage restoring division steps on magnitudes.
module iaedm_div_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  iaedm_pkg::t_side                 i_side,
    input  logic [iaedm_pkg::MagWidth-1:0]   i_rem,
    input  logic [iaedm_pkg::MagWidth-1:0]   i_quo,
    input  logic [iaedm_pkg::MagWidth-1:0]   i_div,
    output logic                             o_valid,
    output iaedm_pkg::t_side                 o_side,
    output logic [iaedm_pkg::MagWidth-1:0]   o_rem,
    output logic [iaedm_pkg::MagWidth-1:0]   o_quo,
    output logic [iaedm_pkg::MagWidth-1:0]   o_div
);
    localparam int W = iaedm_pkg::MagWidth;

    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;

    // Shift-subtract steps; quotient register shifts dividend bits out the top
    always_comb begin
        logic [W:0] t;
        n_rem = i_rem;
        n_quo = i_quo;
        for (int k = 0; k < iaedm_pkg::StepsPerStage; k++) begin
            t = {n_rem, n_quo[W-1]};
            n_quo = {n_quo[W-2:0], 1'b0};
            if (t >= {1'b0, i_div}) begin
                t = t - {1'b0, i_div};
                n_quo[0] = 1'b1;
            end
            n_rem = t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_rem  <= n_rem;
            o_quo  <= n_quo;
            o_div  <= i_div;
        end
    end
endmodule
